// ----- sv/jse_pkg.sv -----
// Shared types, character codes and helpers for the JSON string escaper.
package jse_pkg;

    localparam int unsigned MaxResults = 13;
    localparam int unsigned BodyMax    = 12;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CTL_BS    = 8'h08;
    localparam logic [7:0] CTL_TAB   = 8'h09;
    localparam logic [7:0] CTL_LF    = 8'h0A;
    localparam logic [7:0] CTL_FF    = 8'h0C;
    localparam logic [7:0] CTL_CR    = 8'h0D;

    typedef struct packed {
        logic        in_str;
        logic [1:0]  pend;
        logic [20:0] acc;
    } t_str_state;

    typedef struct packed {
        logic [MaxResults-1:0][7:0] chars;
        logic [3:0]                 count;
        logic                       closed;
    } t_plan;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'b0, nib};
        end else begin
            ch = 8'h57 + {4'b0, nib};
        end
        return ch;
    endfunction

endpackage

// ----- sv/json_string_escaper.sv -----
// JSON string escaper: streams string bytes out as quoted, escaped characters.
//
// Input channel (i_valid / o_stall): one item per string byte, or one item
// flagged empty for an empty string. An item is taken when i_valid is high
// and o_stall is low. Output channel (o_valid / i_stall): one item per output
// character; o_last_result marks the last character an input item caused,
// o_string_closed marks the closing quote.
// Each input item is planned into a character buffer; characters then leave
// one per cycle, while the output is not stalled, through an output register,
// so the first character of an item passes through the buffer and then the
// output register. An item causing N characters holds the input until the
// buffer drains (up to 13 characters for a surrogate pair with the closing
// quote); items causing no character do not hold the input. The buffer's
// drain rate sets throughput.
// A stall on the output holds the output register and, while the buffer
// still holds characters, stalls the input.
// Config port (i_cfg_valid / o_cfg_ready) writes escape_unicode; always ready.
// Reset empties the buffer, clears the output valid flag, the string state and
// escape_unicode.
module json_string_escaper
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_of_string,
    input  logic       i_empty_string,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_result,
    output logic       o_string_closed,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_escape_unicode
);

    logic                       r_esc;
    t_str_state                 r_state;
    t_str_state                 n_state;
    t_plan                      n_plan;
    logic [MaxResults-1:0][7:0] r_chars;
    logic [3:0]                 r_left;
    logic                       r_closed;
    logic                       r_ovalid;
    logic [7:0]                 r_ochar;
    logic                       r_olast;
    logic                       r_oclosed;
    logic                       adv;
    logic                       accept;

    jse_plan u_plan (
        .i_byte_value     (i_byte_value),
        .i_last_of_string (i_last_of_string),
        .i_empty_string   (i_empty_string),
        .i_escape_unicode (r_esc),
        .i_state          (r_state),
        .o_state          (n_state),
        .o_plan           (n_plan)
    );

    assign adv         = ~r_ovalid | ~i_stall;
    assign o_stall     = ~((r_left == 4'd0) || (r_left == 4'd1 && adv));
    assign accept      = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    assign o_valid         = r_ovalid;
    assign o_out_char      = r_ochar;
    assign o_last_result   = r_olast;
    assign o_string_closed = r_oclosed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_esc <= i_cfg_escape_unicode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_left   <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_left  <= n_plan.count;
            end else if (adv && r_left != 4'd0) begin
                r_left <= r_left - 4'd1;
            end
            if (adv) begin
                r_ovalid <= (r_left != 4'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_chars  <= n_plan.chars;
            r_closed <= n_plan.closed;
        end else if (adv && r_left != 4'd0) begin
            r_chars <= {8'h00, r_chars[MaxResults-1:1]};
        end
        if (adv) begin
            r_ochar   <= r_chars[0];
            r_olast   <= (r_left == 4'd1);
            r_oclosed <= r_closed && (r_left == 4'd1);
        end
    end

`ifndef ASSERT_OFF
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 4'(MaxResults))
        else $error("buffer count exceeds maximum");

    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_left <= 4'd1))
        else $error("item taken while buffer still busy");

    a_closed_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oclosed) |-> (r_olast && r_ochar == CH_QUOTE))
        else $error("closing quote not last or not a quote");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_left == 4'd0 && !r_ovalid && !r_state.in_str))
        else $error("reset did not clear control state");

    a_pend_in_str: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pend != 2'd0) |-> r_state.in_str)
        else $error("pending sequence outside a string");
`endif

endmodule

// ----- sv/jse_plan.sv -----
// Per-item escape planner: characters to emit and next string state.
module jse_plan
    import jse_pkg::*;
(
    input  logic [7:0] i_byte_value,
    input  logic       i_last_of_string,
    input  logic       i_empty_string,
    input  logic       i_escape_unicode,
    input  t_str_state i_state,
    output t_str_state o_state,
    output t_plan      o_plan
);

    logic [BodyMax-1:0][7:0] body;
    logic [3:0]              blen;
    logic                    do_cp;
    logic [20:0]             cp;
    logic [20:0]             acc_n;
    logic [1:0]              pend_n;
    logic [20:0]             lead_acc;
    logic [1:0]              lead_extra;
    logic [7:0]              short_ch;
    logic                    is_short;
    logic                    big;
    logic [20:0]             v;
    logic [15:0]             hi;
    logic [15:0]             lo;
    logic [15:0]             w0;
    logic                    open;
    logic [3:0]              kk;
    logic [3:0]              idx;

    always_comb begin
        o_state  = i_state;
        body     = '0;
        blen     = 4'd0;
        do_cp    = 1'b0;
        cp       = '0;
        acc_n    = {i_state.acc[14:0], i_byte_value[5:0]};
        pend_n   = i_state.pend - 2'd1;
        open     = ~i_state.in_str;

        if (i_byte_value[7:5] == 3'b110) begin
            lead_acc = {16'b0, i_byte_value[4:0]};  lead_extra = 2'd1;
        end else if (i_byte_value[7:4] == 4'b1110) begin
            lead_acc = {17'b0, i_byte_value[3:0]};  lead_extra = 2'd2;
        end else if (i_byte_value[7:3] == 5'b11110) begin
            lead_acc = {18'b0, i_byte_value[2:0]};  lead_extra = 2'd3;
        end else begin
            lead_acc = {13'b0, i_byte_value};       lead_extra = 2'd0;
        end

        is_short = 1'b1;
        case (i_byte_value)
            CTL_BS:    short_ch = CH_LOW_B;
            CTL_FF:    short_ch = CH_LOW_F;
            CTL_LF:    short_ch = CH_LOW_N;
            CTL_CR:    short_ch = CH_LOW_R;
            CTL_TAB:   short_ch = CH_LOW_T;
            CH_QUOTE:  short_ch = CH_QUOTE;
            CH_BSLASH: short_ch = CH_BSLASH;
            default: begin
                short_ch = i_byte_value;
                is_short = 1'b0;
            end
        endcase

        o_state.in_str = 1'b1;
        if (i_state.pend != 2'd0) begin
            o_state.acc  = acc_n;
            o_state.pend = pend_n;
            if (pend_n == 2'd0 || i_last_of_string) begin
                do_cp = 1'b1;
                cp    = acc_n;
            end
        end else if (is_short) begin
            body[0] = CH_BSLASH;
            body[1] = short_ch;
            blen    = 4'd2;
        end else if (i_byte_value < 8'h20) begin
            do_cp = 1'b1;
            cp    = {13'b0, i_byte_value};
        end else if (i_byte_value < 8'h80 || !i_escape_unicode) begin
            body[0] = i_byte_value;
            blen    = 4'd1;
        end else if (lead_extra == 2'd0 || i_last_of_string) begin
            do_cp = 1'b1;
            cp    = lead_acc;
        end else begin
            o_state.acc  = lead_acc;
            o_state.pend = lead_extra;
        end

        big = cp > 21'h00FFFF;
        v   = cp - 21'h010000;
        hi  = 16'hD800 + {5'b0, v[20:10]};
        lo  = 16'hDC00 + {6'b0, v[9:0]};
        w0  = big ? hi : cp[15:0];
        if (do_cp) begin
            body[0] = CH_BSLASH;
            body[1] = CH_LOW_U;
            body[2] = hex_char(w0[15:12]);
            body[3] = hex_char(w0[11:8]);
            body[4] = hex_char(w0[7:4]);
            body[5] = hex_char(w0[3:0]);
            blen    = 4'd6;
            if (big) begin
                body[6]  = CH_BSLASH;
                body[7]  = CH_LOW_U;
                body[8]  = hex_char(lo[15:12]);
                body[9]  = hex_char(lo[11:8]);
                body[10] = hex_char(lo[7:4]);
                body[11] = hex_char(lo[3:0]);
                blen     = 4'd12;
            end
        end

        if (i_last_of_string) begin
            o_state = '0;
        end

        o_plan.chars  = '0;
        o_plan.count  = {3'b0, open} + blen + {3'b0, i_last_of_string};
        o_plan.closed = i_last_of_string;
        for (int k = 0; k < MaxResults; k++) begin
            kk  = 4'(k);
            idx = kk - {3'b0, open};
            if (open && kk == 4'd0) begin
                o_plan.chars[k] = CH_QUOTE;
            end else if (idx < blen) begin
                o_plan.chars[k] = body[idx];
            end else if (idx == blen && i_last_of_string) begin
                o_plan.chars[k] = CH_QUOTE;
            end
        end

        if (i_empty_string) begin
            o_state       = '0;
            o_plan.chars  = '0;
            o_plan.chars[0] = CH_QUOTE;
            o_plan.chars[1] = CH_QUOTE;
            o_plan.count  = 4'd2;
            o_plan.closed = 1'b1;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for json_string_escaper: scored against an in-file escaping predictor.
`timescale 1ns / 1ps

module testbench;
    import jse_pkg::*;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;

    typedef struct {
        bit [7:0] b;
        bit       fin;
        bit       empty;
    } t_byte_item;

    typedef struct {
        bit [7:0] ch;
        bit       is_last;
        bit       closed;
    } t_out_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_last_of_string = 1'b0;
    logic       i_empty_string = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_char;
    logic       o_last_result;
    logic       o_string_closed;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_escape_unicode = 1'b0;

    t_byte_item bytes_pending[$];
    t_out_char  chars_due[$];
    int         errors = 0;
    bit         no_idle = 1'b0;

    // shadow of the escaper's register and string state
    bit        esc_unicode = 1'b0;
    bit        str_open = 1'b0;
    bit [1:0]  cont_left = 2'd0;
    bit [20:0] code_acc = 21'd0;

    json_string_escaper i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_byte_value        (i_byte_value),
        .i_last_of_string    (i_last_of_string),
        .i_empty_string      (i_empty_string),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_out_char          (o_out_char),
        .o_last_result       (o_last_result),
        .o_string_closed     (o_string_closed),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_escape_unicode(i_cfg_escape_unicode)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    function automatic void emit(input bit [7:0] ch, input bit closed);
        t_out_char e;
        e.ch = ch;
        e.is_last = 1'b0;
        e.closed = closed;
        chars_due.push_back(e);
    endfunction

    function automatic void emit_pair(input bit [7:0] ch);
        emit(CH_BSLASH, 1'b0);
        emit(ch, 1'b0);
    endfunction

    function automatic bit [7:0] hex_digit(input bit [3:0] nib);
        return (nib < 4'd10) ? CH_ZERO + {4'd0, nib} : CH_LOW_A + {4'd0, nib - 4'd10};
    endfunction

    function automatic void emit_hex4(input bit [15:0] v);
        emit(CH_BSLASH, 1'b0);
        emit(CH_LOW_U, 1'b0);
        emit(hex_digit(v[15:12]), 1'b0);
        emit(hex_digit(v[11:8]), 1'b0);
        emit(hex_digit(v[7:4]), 1'b0);
        emit(hex_digit(v[3:0]), 1'b0);
    endfunction

    function automatic void emit_code_point(input bit [20:0] cp);
        bit [31:0] v;
        bit [31:0] hi;
        bit [31:0] lo;
        if (cp > 21'h00FFFF) begin
            v = {11'd0, cp} - 32'h10000;
            hi = 32'hD800 + (v >> 10);
            lo = 32'hDC00 + (v & 32'h3FF);
            emit_hex4(hi[15:0]);
            emit_hex4(lo[15:0]);
        end else begin
            emit_hex4(cp[15:0]);
        end
    endfunction

    function automatic void clear_string();
        str_open = 1'b0;
        cont_left = 2'd0;
        code_acc = 21'd0;
    endfunction

    // works out the characters one accepted byte item produces
    function automatic void escape_byte(input bit [7:0] c, input bit fin, input bit empty);
        int unsigned first;
        bit [20:0]   lead_val;
        bit [1:0]    extra;
        t_out_char   tail;
        first = chars_due.size();
        if (empty) begin
            clear_string();
            emit(CH_QUOTE, 1'b0);
            emit(CH_QUOTE, 1'b1);
        end else begin
            if (!str_open) begin
                str_open = 1'b1;
                emit(CH_QUOTE, 1'b0);
            end
            if (cont_left != 2'd0) begin
                // continuation bytes are taken on trust, only the low 6 bits count
                code_acc = {code_acc[14:0], c[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0 || fin) begin
                    emit_code_point(code_acc);
                end
            end else begin
                case (c)
                    CH_QUOTE, CH_BSLASH: emit_pair(c);
                    CTL_BS:              emit_pair(CH_LOW_B);
                    CTL_FF:              emit_pair(CH_LOW_F);
                    CTL_LF:              emit_pair(CH_LOW_N);
                    CTL_CR:              emit_pair(CH_LOW_R);
                    CTL_TAB:             emit_pair(CH_LOW_T);
                    default: begin
                        if (c < 8'h20) begin
                            emit_hex4({8'h00, c});
                        end else if (c < 8'h80 || !esc_unicode) begin
                            emit(c, 1'b0);
                        end else begin
                            if (c[7:5] == 3'b110) begin
                                lead_val = {16'd0, c[4:0]};
                                extra = 2'd1;
                            end else if (c[7:4] == 4'b1110) begin
                                lead_val = {17'd0, c[3:0]};
                                extra = 2'd2;
                            end else if (c[7:3] == 5'b11110) begin
                                lead_val = {18'd0, c[2:0]};
                                extra = 2'd3;
                            end else begin
                                lead_val = {13'd0, c};
                                extra = 2'd0;
                            end
                            if (extra == 2'd0 || fin) begin
                                emit_code_point(lead_val);
                            end else begin
                                code_acc = lead_val;
                                cont_left = extra;
                            end
                        end
                    end
                endcase
            end
            if (fin) begin
                clear_string();
                emit(CH_QUOTE, 1'b1);
            end
        end
        if (chars_due.size() > first) begin
            tail = chars_due.pop_back();
            tail.is_last = 1'b1;
            chars_due.push_back(tail);
        end
    endfunction

    function automatic void put_item(input bit [7:0] b, input bit fin, input bit empty);
        t_byte_item it;
        it.b = b;
        it.fin = fin;
        it.empty = empty;
        bytes_pending.push_back(it);
    endfunction

    // random strings, mostly well-formed text and UTF-8 with some noise mixed in
    task automatic add_random_strings(input int target);
        int       made;
        int       len;
        int       kind;
        int       k;
        bit       abandon;
        bit [20:0] cp;
        bit [7:0] seq[$];
        bit [7:0] esc_set[7];
        esc_set = '{CH_QUOTE, CH_BSLASH, CTL_BS, CTL_FF, CTL_LF, CTL_CR, CTL_TAB};
        made = 0;
        while (made < target) begin
            if ($urandom_range(99) < 6) begin
                put_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                made++;
            end else begin
                seq.delete();
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    kind = $urandom_range(99);
                    if (kind < 40) begin
                        seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    end else if (kind < 50) begin
                        seq.push_back(esc_set[$urandom_range(6)]);
                    end else if (kind < 58) begin
                        seq.push_back(8'($urandom_range(8'h1F)));
                    end else if (kind < 68) begin
                        cp = 21'($urandom_range(21'h80, 21'h7FF));
                        seq.push_back({3'b110, cp[10:6]});
                        seq.push_back({2'b10, cp[5:0]});
                    end else if (kind < 80) begin
                        cp = 21'($urandom_range(21'h800, 21'hFFFF));
                        seq.push_back({4'b1110, cp[15:12]});
                        seq.push_back({2'b10, cp[11:6]});
                        seq.push_back({2'b10, cp[5:0]});
                    end else if (kind < 90) begin
                        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                        seq.push_back({5'b11110, cp[20:18]});
                        seq.push_back({2'b10, cp[17:12]});
                        seq.push_back({2'b10, cp[11:6]});
                        seq.push_back({2'b10, cp[5:0]});
                    end else if (kind < 95) begin
                        seq.push_back(8'($urandom_range(255)));
                    end else begin
                        seq.push_back(8'($urandom_range(8'h80, 8'hFF)));
                    end
                end
                if (seq.size() > 1 && $urandom_range(99) < 8) begin
                    void'(seq.pop_back());
                end
                abandon = ($urandom_range(99) < 4);
                for (k = 0; k < seq.size(); k++) begin
                    put_item(seq[k], !abandon && (k == seq.size() - 1), 1'b0);
                end
                if (abandon) begin
                    put_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                    made++;
                end
                made += seq.size();
            end
        end
    endtask

    task automatic drain();
        while (bytes_pending.size() != 0 || i_valid || chars_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_escape(input bit v);
        i_cfg_valid <= 1'b1;
        i_cfg_escape_unicode <= v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        esc_unicode = v;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : drv
        t_byte_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                escape_byte(i_byte_value, i_last_of_string, i_empty_string);
            end
            if (!i_valid || !o_stall) begin
                if (bytes_pending.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
                    nxt = bytes_pending.pop_front();
                    i_valid <= 1'b1;
                    i_byte_value <= nxt.b;
                    i_last_of_string <= nxt.fin;
                    i_empty_string <= nxt.empty;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : mon
        t_out_char want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (chars_due.size() == 0) begin
                    report_mismatch("unexpected item, out_char", int'(o_out_char), 0);
                end else begin
                    want = chars_due.pop_front();
                    if (o_out_char !== want.ch) begin
                        report_mismatch("out_char", int'(o_out_char), int'(want.ch));
                    end
                    if (o_last_result !== want.is_last) begin
                        report_mismatch("last_result", int'(o_last_result),
                                        int'(want.is_last));
                    end
                    if (o_string_closed !== want.closed) begin
                        report_mismatch("string_closed", int'(o_string_closed),
                                        int'(want.closed));
                    end
                end
            end
            i_stall <= !no_idle && ($urandom_range(99) < 33);
        end
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int p;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // raw mode: escapes, control bytes, high byte passed through
        put_item(8'h00, 1'b0, 1'b1);
        put_item(CH_QUOTE, 1'b0, 1'b0);
        put_item(CH_BSLASH, 1'b0, 1'b0);
        put_item(CTL_BS, 1'b0, 1'b0);
        put_item(CTL_FF, 1'b0, 1'b0);
        put_item(CTL_LF, 1'b0, 1'b0);
        put_item(CTL_CR, 1'b0, 1'b0);
        put_item(CTL_TAB, 1'b0, 1'b0);
        put_item(8'h00, 1'b0, 1'b0);
        put_item(8'hFF, 1'b1, 1'b0);
        drain();

        // unicode mode: 2 and 4 byte sequences, bad lead, cut-short sequence,
        // then an open sequence abandoned by an empty string
        write_escape(1'b1);
        put_item(8'hC3, 1'b0, 1'b0);
        put_item(8'hA9, 1'b0, 1'b0);
        put_item(8'hF0, 1'b0, 1'b0);
        put_item(8'h9F, 1'b0, 1'b0);
        put_item(8'h98, 1'b0, 1'b0);
        put_item(8'h80, 1'b0, 1'b0);
        put_item(8'hFF, 1'b0, 1'b0);
        put_item(8'hE2, 1'b0, 1'b0);
        put_item(8'h82, 1'b1, 1'b0);
        put_item(8'hE2, 1'b0, 1'b0);
        put_item(8'hFF, 1'b1, 1'b1);
        put_item(8'hE2, 1'b0, 1'b0);
        drain();

        // register cleared in the middle of a sequence: decoding still finishes
        write_escape(1'b0);
        put_item(8'h82, 1'b0, 1'b0);
        put_item(8'hAC, 1'b1, 1'b0);
        drain();

        for (p = 0; p < 5; p++) begin
            write_escape(p % 2 == 0);
            no_idle = (p == 2);
            add_random_strings(90);
            drain();
        end
        no_idle = 1'b0;

        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
